// ----- rtl/suffix_automaton_builder_core_defines.svh -----
// Assertion helpers used by the RTL datapath.
`ifndef SUFFIX_AUTOMATON_BUILDER_CORE_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SAB_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SAB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sab_pkg.sv -----
package sab_pkg;

  localparam int MAX_STATES  = 8192;
  localparam int ALPHABET    = 26;
  localparam int SW          = 13;
  localparam int CW          = 5;
  localparam int GW          = 3;
  localparam int TABLE_DEPTH = MAX_STATES * ALPHABET;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int IW          = $clog2(ALPHABET);
  localparam int ROOM_LIMIT  = MAX_STATES - 3;

  typedef struct packed {
    logic [GW-1:0] gen;
    logic [SW-1:0] val;
  } nt_entry_t;

  // controller states, also the datapath micro-op
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_GEN   = 5'd1;
  localparam logic [4:0] S_CLR   = 5'd2;
  localparam logic [4:0] S_ROOT  = 5'd3;
  localparam logic [4:0] S_CHECK = 5'd4;
  localparam logic [4:0] S_NEW   = 5'd5;
  localparam logic [4:0] S_NEWW  = 5'd6;
  localparam logic [4:0] S_W1    = 5'd7;
  localparam logic [4:0] S_W2    = 5'd8;
  localparam logic [4:0] S_W3    = 5'd9;
  localparam logic [4:0] S_C1    = 5'd10;
  localparam logic [4:0] S_C2    = 5'd11;
  localparam logic [4:0] S_C3    = 5'd12;
  localparam logic [4:0] S_CP1   = 5'd13;
  localparam logic [4:0] S_CP2   = 5'd14;
  localparam logic [4:0] S_R1    = 5'd15;
  localparam logic [4:0] S_R2    = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  typedef logic [4:0] op_t;

  typedef struct packed {
    logic restart;
    logic gen_max;
    logic clr_last;
    logic sym_ok;
    logic hit;
    logic link_zero;
    logic len_match;
    logic copy_last;
    logic eq_q;
    logic out_free;
  } status_t;

  function automatic logic [AW-1:0] slot(input logic [SW-1:0] s, input logic [IW-1:0] c);
    slot = AW'(s) * AW'(ALPHABET) + AW'(c);
  endfunction

endpackage

// ----- rtl/sab_in_if.sv -----
interface sab_in_if;
  logic                     valid;
  logic                     ready;
  logic [sab_pkg::CW-1:0]   symbol;
  logic                     restart;
  modport source (output valid, symbol, restart, input ready);
  modport sink (input valid, symbol, restart, output ready);
endinterface

// ----- rtl/sab_out_if.sv -----
interface sab_out_if;
  logic                     valid;
  logic                     ready;
  logic [sab_pkg::SW-1:0]   new_state;
  logic [sab_pkg::SW-1:0]   link_state;
  logic [sab_pkg::SW-1:0]   longest_len;
  logic                     clone_made;
  logic [sab_pkg::SW-1:0]   state_total;
  logic                     overflow;
  modport source (output valid, new_state, link_state, longest_len, clone_made, state_total,
                  overflow, input ready);
  modport sink (input valid, new_state, link_state, longest_len, clone_made, state_total,
                overflow, output ready);
endinterface

// ----- rtl/sab_ctrl.sv -----
module sab_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  sab_pkg::status_t  status,
  output logic              in_ready,
  output sab_pkg::op_t      op
);

  logic [4:0] state;
  logic [4:0] state_next;
  logic       pending;

  assign op       = state;
  assign in_ready = (state == sab_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      sab_pkg::S_IDLE: begin
        if (in_fire) state_next = status.restart ? sab_pkg::S_GEN : sab_pkg::S_CHECK;
      end
      sab_pkg::S_GEN:   state_next = status.gen_max ? sab_pkg::S_CLR : sab_pkg::S_ROOT;
      sab_pkg::S_CLR:   if (status.clr_last) state_next = sab_pkg::S_ROOT;
      sab_pkg::S_ROOT:  state_next = pending ? sab_pkg::S_CHECK : sab_pkg::S_IDLE;
      sab_pkg::S_CHECK: state_next = status.sym_ok ? sab_pkg::S_NEW : sab_pkg::S_DONE;
      sab_pkg::S_NEW:   state_next = sab_pkg::S_NEWW;
      sab_pkg::S_NEWW:  state_next = sab_pkg::S_W1;
      sab_pkg::S_W1:    state_next = sab_pkg::S_W2;
      sab_pkg::S_W2: begin
        if (status.hit) state_next = sab_pkg::S_W3;
        else if (status.link_zero) state_next = sab_pkg::S_DONE;
        else state_next = sab_pkg::S_W1;
      end
      sab_pkg::S_W3:    state_next = status.len_match ? sab_pkg::S_DONE : sab_pkg::S_C1;
      sab_pkg::S_C1:    state_next = sab_pkg::S_C2;
      sab_pkg::S_C2:    state_next = sab_pkg::S_C3;
      sab_pkg::S_C3:    state_next = sab_pkg::S_CP1;
      sab_pkg::S_CP1:   state_next = sab_pkg::S_CP2;
      sab_pkg::S_CP2:   state_next = status.copy_last ? sab_pkg::S_R1 : sab_pkg::S_CP1;
      sab_pkg::S_R1:    state_next = sab_pkg::S_R2;
      sab_pkg::S_R2: begin
        state_next = (status.eq_q && !status.link_zero) ? sab_pkg::S_R1 : sab_pkg::S_DONE;
      end
      sab_pkg::S_DONE:  if (status.out_free) state_next = sab_pkg::S_IDLE;
      default:          state_next = sab_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sab_pkg::S_CLR;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) pending <= 1'b1;
      else if (state == sab_pkg::S_DONE) pending <= 1'b0;
    end
  end

endmodule

// ----- rtl/sab_datapath.sv -----
`include "suffix_automaton_builder_core_defines.svh"

module sab_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  sab_pkg::op_t      op,
  sab_in_if.sink            in_ch,
  sab_out_if.source         out_ch,
  output sab_pkg::status_t  status
);

  sab_pkg::nt_entry_t     nt_mem [sab_pkg::TABLE_DEPTH];
  logic [sab_pkg::SW-1:0] lk_mem [sab_pkg::MAX_STATES];
  logic [sab_pkg::SW-1:0] ln_mem [sab_pkg::MAX_STATES];

  sab_pkg::nt_entry_t     nt_rd;
  logic [sab_pkg::SW-1:0] lk_rd;
  logic [sab_pkg::SW-1:0] ln_rd;

  logic                   nt_we;
  logic [sab_pkg::AW-1:0] nt_wa;
  sab_pkg::nt_entry_t     nt_wd;
  logic [sab_pkg::AW-1:0] nt_ra;
  logic                   lk_we;
  logic [sab_pkg::SW-1:0] lk_wa;
  logic [sab_pkg::SW-1:0] lk_wd;
  logic [sab_pkg::SW-1:0] lk_ra;
  logic                   ln_we;
  logic [sab_pkg::SW-1:0] ln_wa;
  logic [sab_pkg::SW-1:0] ln_wd;
  logic [sab_pkg::SW-1:0] ln_ra;

  logic [sab_pkg::CW-1:0] symbol;
  logic [sab_pkg::GW-1:0] gen;
  logic [sab_pkg::SW-1:0] last_state;
  logic [sab_pkg::SW-1:0] state_count;
  logic [sab_pkg::SW-1:0] p;
  logic [sab_pkg::SW-1:0] q;
  logic [sab_pkg::SW-1:0] np;
  logic [sab_pkg::SW-1:0] nq;
  logic [sab_pkg::SW-1:0] len_p;
  logic [sab_pkg::SW-1:0] len_np;
  logic [sab_pkg::SW-1:0] link_np;
  logic                   appended;
  logic                   clone;
  logic                   ovf;
  logic [sab_pkg::IW-1:0] idx;
  logic [sab_pkg::AW-1:0] clr_addr;

  logic [sab_pkg::IW-1:0] sym_c;
  logic                   in_alpha;
  logic                   room;
  logic [sab_pkg::SW-1:0] nt_val;
  logic [sab_pkg::SW-1:0] count_inc;
  logic [sab_pkg::SW-1:0] len_p_inc;
  logic                   out_free;

  assign sym_c     = symbol[sab_pkg::IW-1:0];
  assign in_alpha  = (symbol < sab_pkg::CW'(sab_pkg::ALPHABET));
  assign room      = (state_count <= sab_pkg::SW'(sab_pkg::ROOM_LIMIT));
  assign nt_val    = (nt_rd.gen == gen) ? nt_rd.val : '0;
  assign count_inc = state_count + sab_pkg::SW'(1);
  assign len_p_inc = len_p + sab_pkg::SW'(1);
  assign out_free  = !out_ch.valid || out_ch.ready;

  assign status.restart   = in_ch.restart;
  assign status.gen_max   = (gen == '1);
  assign status.clr_last  = (clr_addr == sab_pkg::AW'(sab_pkg::TABLE_DEPTH - 1));
  assign status.sym_ok    = in_alpha && room;
  assign status.hit       = (nt_val != '0);
  assign status.link_zero = (lk_rd == '0);
  assign status.len_match = (ln_rd == len_p_inc);
  assign status.copy_last = (idx == sab_pkg::IW'(sab_pkg::ALPHABET - 1));
  assign status.eq_q      = (nt_val == q);
  assign status.out_free  = out_free;

  always_comb begin
    nt_we = 1'b0;
    nt_wa = sab_pkg::slot(p, sym_c);
    nt_wd = '{gen: gen, val: np};
    nt_ra = sab_pkg::slot(p, sym_c);
    lk_we = 1'b0;
    lk_wa = np;
    lk_wd = '0;
    lk_ra = p;
    ln_we = 1'b0;
    ln_wa = np;
    ln_wd = '0;
    ln_ra = p;
    unique case (op)
      sab_pkg::S_CLR: begin
        nt_we = 1'b1;
        nt_wa = clr_addr;
        nt_wd = '0;
      end
      sab_pkg::S_ROOT: begin
        lk_we = 1'b1;
        lk_wa = sab_pkg::SW'(1);
        ln_we = 1'b1;
        ln_wa = sab_pkg::SW'(1);
      end
      sab_pkg::S_NEW: ln_ra = last_state;
      sab_pkg::S_NEWW: begin
        ln_we = 1'b1;
        ln_wd = ln_rd + sab_pkg::SW'(1);
      end
      sab_pkg::S_W2: begin
        ln_ra = nt_val;
        if (nt_val == '0) begin
          nt_we = 1'b1;
          if (lk_rd == '0) begin
            lk_we = 1'b1;
            lk_wd = sab_pkg::SW'(1);
          end
        end
      end
      sab_pkg::S_W3: begin
        lk_ra = q;
        if (ln_rd == len_p_inc) begin
          lk_we = 1'b1;
          lk_wd = q;
        end else begin
          ln_we = 1'b1;
          ln_wa = count_inc;
          ln_wd = len_p_inc;
        end
      end
      sab_pkg::S_C1: begin
        lk_we = 1'b1;
        lk_wa = nq;
        lk_wd = lk_rd;
      end
      sab_pkg::S_C2: begin
        lk_we = 1'b1;
        lk_wa = q;
        lk_wd = nq;
      end
      sab_pkg::S_C3: begin
        lk_we = 1'b1;
        lk_wd = nq;
      end
      sab_pkg::S_CP1: nt_ra = sab_pkg::slot(q, idx);
      sab_pkg::S_CP2: begin
        nt_we = 1'b1;
        nt_wa = sab_pkg::slot(nq, idx);
        nt_wd = '{gen: gen, val: nt_val};
      end
      sab_pkg::S_R2: begin
        if (nt_val == q) begin
          nt_we = 1'b1;
          nt_wd = '{gen: gen, val: nq};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nt_we) nt_mem[nt_wa] <= nt_wd;
    nt_rd <= nt_mem[nt_ra];
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    lk_rd <= lk_mem[lk_ra];
    if (ln_we) ln_mem[ln_wa] <= ln_wd;
    ln_rd <= ln_mem[ln_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen          <= '0;
      last_state   <= sab_pkg::SW'(1);
      state_count  <= sab_pkg::SW'(1);
      clr_addr     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (op == sab_pkg::S_GEN) begin
        gen         <= gen + sab_pkg::GW'(1);
        last_state  <= sab_pkg::SW'(1);
        state_count <= sab_pkg::SW'(1);
      end
      if (op == sab_pkg::S_CLR) begin
        clr_addr <= status.clr_last ? '0 : clr_addr + sab_pkg::AW'(1);
      end
      if (op == sab_pkg::S_NEW) begin
        state_count <= count_inc;
        last_state  <= count_inc;
      end
      if (op == sab_pkg::S_W3 && !status.len_match) state_count <= count_inc;
      if (op == sab_pkg::S_DONE && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      symbol   <= in_ch.symbol;
      appended <= 1'b0;
      clone    <= 1'b0;
    end
    unique case (op)
      sab_pkg::S_CHECK: ovf <= in_alpha && !room;
      sab_pkg::S_NEW: begin
        p        <= last_state;
        np       <= count_inc;
        appended <= 1'b1;
      end
      sab_pkg::S_NEWW: len_np <= ln_rd + sab_pkg::SW'(1);
      sab_pkg::S_W2: begin
        if (nt_val == '0) begin
          p <= lk_rd;
          if (lk_rd == '0) link_np <= sab_pkg::SW'(1);
        end else begin
          q     <= nt_val;
          len_p <= ln_rd;
        end
      end
      sab_pkg::S_W3: begin
        if (ln_rd == len_p_inc) begin
          link_np <= q;
        end else begin
          nq    <= count_inc;
          clone <= 1'b1;
        end
      end
      sab_pkg::S_C3: begin
        link_np <= nq;
        idx     <= '0;
      end
      sab_pkg::S_CP2: idx <= idx + sab_pkg::IW'(1);
      sab_pkg::S_R2: if (nt_val == q) p <= lk_rd;
      sab_pkg::S_DONE: begin
        if (out_free) begin
          out_ch.new_state   <= appended ? np : '0;
          out_ch.link_state  <= appended ? link_np : '0;
          out_ch.longest_len <= appended ? len_np : '0;
          out_ch.clone_made  <= clone;
          out_ch.state_total <= state_count;
          out_ch.overflow    <= ovf;
        end
      end
      default: ;
    endcase
  end

  `SAB_ASSERT_SAME(a_last_le_count, clk, rst, 1'b1, last_state <= state_count,
                   "last_state above state_count")
  `SAB_ASSERT_SAME(a_clone_follows_new, clk, rst, op == sab_pkg::S_CP2,
                   nq == np + sab_pkg::SW'(1), "clone index not after new state")
  `SAB_ASSERT_NEXT(a_gen_resets_root, clk, rst, op == sab_pkg::S_GEN,
                   state_count == sab_pkg::SW'(1) && last_state == sab_pkg::SW'(1),
                   "restart did not return to root")

endmodule

// ----- rtl/suffix_automaton_builder_core.sv -----
// Suffix automaton builder.
// in_ch carries symbol and restart; one transfer appends one symbol to the
// automaton (restart first empties it back to the root). out_ch returns one
// result per input transfer: new state, its suffix link and longest length,
// clone flag, highest state index in use and overflow.
// One item is processed at a time; in_ch.ready is high only while idle, so
// a new transfer is taken only after the previous item has left its final step.
// An appended symbol first derives the new state's length, then walks the
// suffix links step by step; when the walk stops on an existing transition
// the length is compared, and a clone then sets its links, copies the row
// and redirects links. A dropped symbol goes straight to the result. Each
// memory access goes through the registered reads of the transition, link
// and length memories, which sets the pace.
// After reset the transition memory is swept before the first transfer is
// taken; the same sweep runs on every eighth restart. Other restarts only
// bump the generation and rewrite the root.
// A finished result sits in the output register while out_ch.ready is low;
// the next item may be accepted meanwhile and holds in its final step until
// the register frees.
module suffix_automaton_builder_core (
  input  logic       clk,
  input  logic       rst,
  sab_in_if.sink     in_ch,
  sab_out_if.source  out_ch
);

  sab_pkg::status_t status;
  sab_pkg::op_t     op;
  logic             in_ready;
  logic             in_fire;

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;

  sab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  sab_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .op      (op),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .status  (status)
  );

endmodule

// ----- tb/tb_suffix_automaton_builder_core.sv -----
module tb_suffix_automaton_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 4000000;

  typedef struct {
    logic [sab_pkg::CW-1:0] symbol;
    logic                   restart;
  } sym_item_t;

  typedef struct {
    logic [sab_pkg::SW-1:0] new_state;
    logic [sab_pkg::SW-1:0] link_state;
    logic [sab_pkg::SW-1:0] longest_len;
    logic                   clone_made;
    logic [sab_pkg::SW-1:0] state_total;
    logic                   overflow;
  } append_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sab_in_if  in_ch ();
  sab_out_if out_ch ();

  suffix_automaton_builder_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // automaton shadow
  logic [sab_pkg::SW-1:0] sam_next [int];
  logic [sab_pkg::SW-1:0] sam_link [sab_pkg::MAX_STATES];
  logic [sab_pkg::SW-1:0] sam_len  [sab_pkg::MAX_STATES];
  logic [sab_pkg::SW-1:0] sam_last;
  logic [sab_pkg::SW-1:0] sam_count;

  sym_item_t   pending_syms[$];
  append_res_t expected_appends[$];

  int errors = 0;
  int results = 0;
  int clones = 0;
  int overflows = 0;
  int restarts = 0;
  int cycles = 0;

  function automatic logic [sab_pkg::SW-1:0] next_of(logic [sab_pkg::SW-1:0] s,
                                                     logic [sab_pkg::CW-1:0] c);
    int k;
    k = int'(s) * sab_pkg::ALPHABET + int'(c);
    return sam_next.exists(k) ? sam_next[k] : '0;
  endfunction

  function automatic void set_next(logic [sab_pkg::SW-1:0] s, logic [sab_pkg::CW-1:0] c,
                                   logic [sab_pkg::SW-1:0] v);
    sam_next[int'(s) * sab_pkg::ALPHABET + int'(c)] = v;
  endfunction

  function automatic void empty_automaton();
    sam_next.delete();
    foreach (sam_link[i]) begin
      sam_link[i] = '0;
      sam_len[i] = '0;
    end
    sam_last = sab_pkg::SW'(1);
    sam_count = sab_pkg::SW'(1);
  endfunction

  function automatic append_res_t append_symbol(logic [sab_pkg::CW-1:0] c, logic rs);
    append_res_t r;
    logic [sab_pkg::SW-1:0] p, np, q, nq;
    r = '{default: '0};
    if (rs) empty_automaton();
    if (int'(c) < sab_pkg::ALPHABET) begin
      if (sab_pkg::MAX_STATES - 1 - int'(sam_count) < 2) begin
        r.overflow = 1'b1;
      end else begin
        p = sam_last;
        sam_count = sam_count + sab_pkg::SW'(1);
        np = sam_count;
        sam_last = np;
        sam_len[np] = sam_len[p] + sab_pkg::SW'(1);
        while (p != 0 && next_of(p, c) == 0) begin
          set_next(p, c, np);
          p = sam_link[p];
        end
        if (p == 0) begin
          sam_link[np] = sab_pkg::SW'(1);
        end else begin
          q = next_of(p, c);
          if (int'(sam_len[q]) == int'(sam_len[p]) + 1) begin
            sam_link[np] = q;
          end else begin
            sam_count = sam_count + sab_pkg::SW'(1);
            nq = sam_count;
            for (int a = 0; a < sab_pkg::ALPHABET; a++)
              set_next(nq, sab_pkg::CW'(a), next_of(q, sab_pkg::CW'(a)));
            sam_link[nq] = sam_link[q];
            sam_len[nq] = sam_len[p] + sab_pkg::SW'(1);
            sam_link[q] = nq;
            sam_link[np] = nq;
            while (p != 0 && next_of(p, c) == q) begin
              set_next(p, c, nq);
              p = sam_link[p];
            end
            r.clone_made = 1'b1;
          end
        end
        r.new_state = np;
        r.link_state = sam_link[np];
        r.longest_len = sam_len[np];
      end
    end
    r.state_total = sam_count;
    return r;
  endfunction

  task automatic queue_symbol(int c, bit rs);
    sym_item_t it;
    it.symbol = c[sab_pkg::CW-1:0];
    it.restart = rs;
    if (rs) restarts++;
    pending_syms.insert(pending_syms.size(), it);
    expected_appends.insert(expected_appends.size(), append_symbol(it.symbol, rs));
  endtask

  task automatic report(string what, int got, int want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, results);
  endtask

  // sender
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.symbol <= '0;
      in_ch.restart <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_syms.size() > 0) begin
        sym_item_t it;
        it = pending_syms.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.symbol <= it.symbol;
        in_ch.restart <= it.restart;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst && !hold_done && results >= 100) begin
      hold_done <= 1'b1;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 1 || (!hold_done && results >= 100)) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(20, 200);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_appends.size() == 0) begin
        report("unexpected result, new_state", int'(out_ch.new_state), 0);
      end else begin
        append_res_t e;
        e = expected_appends.pop_front();
        if (out_ch.new_state !== e.new_state)
          report("new_state", int'(out_ch.new_state), int'(e.new_state));
        if (out_ch.link_state !== e.link_state)
          report("link_state", int'(out_ch.link_state), int'(e.link_state));
        if (out_ch.longest_len !== e.longest_len)
          report("longest_len", int'(out_ch.longest_len), int'(e.longest_len));
        if (out_ch.clone_made !== e.clone_made)
          report("clone_made", int'(out_ch.clone_made), int'(e.clone_made));
        if (out_ch.state_total !== e.state_total)
          report("state_total", int'(out_ch.state_total), int'(e.state_total));
        if (out_ch.overflow !== e.overflow)
          report("overflow", int'(out_ch.overflow), int'(e.overflow));
        clones += int'(e.clone_made);
        overflows += int'(e.overflow);
      end
      results++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    empty_automaton();
    // directed
    queue_symbol(0, 1'b0);
    queue_symbol(25, 1'b0);
    queue_symbol(31, 1'b0);
    queue_symbol(26, 1'b0);
    queue_symbol(0, 1'b0);
    queue_symbol(0, 1'b1);
    queue_symbol(0, 1'b0);
    queue_symbol(1, 1'b0);
    queue_symbol(0, 1'b0);
    queue_symbol(1, 1'b0);
    queue_symbol(1, 1'b0);
    queue_symbol(0, 1'b0);
    queue_symbol(30, 1'b1);
    queue_symbol(16, 1'b0);
    queue_symbol(15, 1'b0);
    queue_symbol(16, 1'b0);
    queue_symbol(17, 1'b1);
    // random strings, mostly over a small alphabet so clones happen
    for (int n = 0; n < 1200; n++) begin
      int c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) c = $urandom_range(0, 2);
      else if (pick < 94) c = $urandom_range(0, 25);
      else c = $urandom_range(26, 31);
      queue_symbol(c, $urandom_range(0, 99) == 0);
    end
    queue_symbol(1, 1'b0);
    queue_symbol(25, 1'b0);
    queue_symbol(31, 1'b0);
    queue_symbol(7, 1'b1);
    queue_symbol(7, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_syms.size() > 0 || expected_appends.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d results, %0d clones, %0d overflows, %0d restarts in %0d cycles",
             results, clones, overflows, restarts, cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
